// ----- hdl/llt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package llt_pkg;

    // entry id width, fixed by the request and result fields
    localparam int ID_W = 10;

    // request codes
    localparam logic [1:0] REQ_INS_LEFT  = 2'd0;
    localparam logic [1:0] REQ_INS_RIGHT = 2'd1;
    localparam logic [1:0] REQ_REMOVE    = 2'd2;
    localparam logic [1:0] REQ_QUERY     = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_IN_LIST = 2'd1;
    localparam logic [1:0] ST_REMOVED     = 2'd2;
    localparam logic [1:0] ST_BAD_NEW     = 2'd3;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // classified request as it travels to the back end
    typedef struct packed {
        logic [1:0]      req_type;
        logic [ID_W-1:0] anchor_id;
        logic [ID_W-1:0] new_id;
        logic            anchor_zero;
        logic            anchor_in_range;
        logic            new_zero;
        logic            new_in_range;
    } req_t;

    // per-entry marks
    typedef struct packed {
        logic removed;
        logic member;
    } mark_t;

endpackage

`default_nettype wire

// ----- hdl/llt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llt_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/llt_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llt_front
    import llt_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [1:0]      req_type,
    input  wire logic [ID_W-1:0] anchor_id,
    input  wire logic [ID_W-1:0] new_id,
    input  wire logic            clearing,
    output logic                 q_valid,
    output req_t                 q_item,
    input  wire logic            q_pop
);

    req_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              in_fire;
    logic              out_fire;
    req_t              cls;

    // classify the incoming beat
    always_comb
    begin
        cls.req_type        = req_type;
        cls.anchor_id       = anchor_id;
        cls.new_id          = new_id;
        cls.anchor_zero     = (anchor_id == '0);
        cls.anchor_in_range = (32'(anchor_id) < 32'(ENTRIES));
        cls.new_zero        = (new_id == '0);
        cls.new_in_range    = (32'(new_id) < 32'(ENTRIES));
    end

    // no beats while full or while the mark store is being cleared
    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH)) || clearing;
    assign in_fire  = push && !full;
    assign q_valid  = (count_reg != '0);
    assign out_fire = q_pop && q_valid;
    assign q_item   = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = in_fire  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = out_fire ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({in_fire, out_fire})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/llt_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llt_back
    import llt_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    output logic                 clearing,
    input  wire logic            q_valid,
    input  wire req_t            q_item,
    output logic                 q_pop,
    output logic                 empty,
    input  wire logic            pop,
    output logic [1:0]           status,
    output logic [ID_W-1:0]      left_neighbor,
    output logic [ID_W-1:0]      right_neighbor,
    output logic [ID_W-1:0]      first_entry,
    output logic [ID_W-1:0]      last_entry
);

    localparam int AW = $clog2(ENTRIES);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_WR2   = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    req_t            cur_reg, cur_next;
    logic [ID_W-1:0] head_reg, head_next;
    logic [ID_W-1:0] tail_reg, tail_next;

    // second write batch of an insert
    logic            l2_en_reg, l2_en_next;
    logic [ID_W-1:0] l2_addr_reg, l2_addr_next;
    logic [ID_W-1:0] l2_data_reg, l2_data_next;
    logic            r2_en_reg, r2_en_next;
    logic [ID_W-1:0] r2_addr_reg, r2_addr_next;
    logic [ID_W-1:0] r2_data_reg, r2_data_next;
    logic [ID_W-1:0] pend_ln_reg, pend_ln_next;
    logic [ID_W-1:0] pend_rn_reg, pend_rn_next;

    // result register
    logic            out_valid_reg, out_valid_next;
    logic [1:0]      out_status_reg, out_status_next;
    logic [ID_W-1:0] out_ln_reg, out_ln_next;
    logic [ID_W-1:0] out_rn_reg, out_rn_next;
    logic [ID_W-1:0] out_first_reg, out_first_next;
    logic [ID_W-1:0] out_last_reg, out_last_next;

    // memory ports
    logic            lw_en, rw_en, mw_en;
    logic [ID_W-1:0] lw_addr, lw_data, rw_addr, rw_data;
    logic [AW-1:0]   mw_addr;
    mark_t           mw_data;
    logic [ID_W-1:0] la_q, ra_q;
    mark_t           mka_q, mkn_q;

    // decode of the current request
    logic            start, pop_fire;
    logic            anchor_live, anchor_removed, new_ok;
    logic            ins_ok, rem_ok;
    logic [ID_W-1:0] a_id, n_id, succ;
    logic [1:0]      res_status;
    logic [ID_W-1:0] res_ln, res_rn;

    llt_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_left_links (
        .clk   (clk),
        .we    (lw_en),
        .waddr (AW'(lw_addr)),
        .wdata (lw_data),
        .raddr (AW'(q_item.anchor_id)),
        .rdata (la_q)
    );

    llt_ram #(.WIDTH(ID_W), .DEPTH(ENTRIES)) u_right_links (
        .clk   (clk),
        .we    (rw_en),
        .waddr (AW'(rw_addr)),
        .wdata (rw_data),
        .raddr (AW'(q_item.anchor_id)),
        .rdata (ra_q)
    );

    // marks are kept twice so anchor and new id read in the same cycle
    llt_ram #(.WIDTH($bits(mark_t)), .DEPTH(ENTRIES)) u_marks_anchor (
        .clk   (clk),
        .we    (mw_en),
        .waddr (mw_addr),
        .wdata (mw_data),
        .raddr (AW'(q_item.anchor_id)),
        .rdata (mka_q)
    );

    llt_ram #(.WIDTH($bits(mark_t)), .DEPTH(ENTRIES)) u_marks_new (
        .clk   (clk),
        .we    (mw_en),
        .waddr (mw_addr),
        .wdata (mw_data),
        .raddr (AW'(q_item.new_id)),
        .rdata (mkn_q)
    );

    assign pop_fire = pop && out_valid_reg;
    assign start    = (state_reg == S_IDLE) && q_valid && (!out_valid_reg || pop_fire);
    assign q_pop    = start;
    assign clearing = (state_reg == S_CLEAR);

    // classify against the marks read for the current request
    always_comb
    begin
        a_id           = cur_reg.anchor_id;
        n_id           = cur_reg.new_id;
        anchor_live    = !cur_reg.anchor_zero && cur_reg.anchor_in_range && mka_q.member;
        anchor_removed = !cur_reg.anchor_zero && cur_reg.anchor_in_range && mka_q.removed;
        new_ok         = !cur_reg.new_zero && cur_reg.new_in_range
                         && !mkn_q.member && !mkn_q.removed;
        succ           = cur_reg.anchor_zero ? head_reg : ra_q;
        ins_ok         = 1'b0;
        rem_ok         = 1'b0;
        res_status     = ST_OK;
        res_ln         = '0;
        res_rn         = '0;
        unique case (cur_reg.req_type)
            REQ_INS_LEFT:
            begin
                if (!anchor_live)
                begin
                    res_status = ST_NOT_IN_LIST;
                end
                else if (!new_ok)
                begin
                    res_status = ST_BAD_NEW;
                end
                else
                begin
                    ins_ok = 1'b1;
                    res_ln = n_id;
                    res_rn = ra_q;
                end
            end
            REQ_INS_RIGHT:
            begin
                if (!(anchor_live || cur_reg.anchor_zero))
                begin
                    res_status = ST_NOT_IN_LIST;
                end
                else if (!new_ok)
                begin
                    res_status = ST_BAD_NEW;
                end
                else
                begin
                    ins_ok = 1'b1;
                    res_ln = cur_reg.anchor_zero ? '0 : la_q;
                    res_rn = n_id;
                end
            end
            REQ_REMOVE:
            begin
                if (anchor_live)
                begin
                    rem_ok = 1'b1;
                    res_ln = la_q;
                    res_rn = ra_q;
                end
                else if (anchor_removed)
                begin
                    res_status = ST_REMOVED;
                end
                else
                begin
                    res_status = ST_NOT_IN_LIST;
                end
            end
            REQ_QUERY:
            begin
                if (cur_reg.anchor_zero)
                begin
                    res_rn = head_reg;
                end
                else if (anchor_live)
                begin
                    res_ln = la_q;
                    res_rn = ra_q;
                end
                else
                begin
                    res_status = ST_NOT_IN_LIST;
                end
            end
            default:
            begin
                res_status = ST_NOT_IN_LIST;
            end
        endcase
    end

    // sequencer, link writes and result register
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        cur_next        = cur_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        l2_en_next      = l2_en_reg;
        l2_addr_next    = l2_addr_reg;
        l2_data_next    = l2_data_reg;
        r2_en_next      = r2_en_reg;
        r2_addr_next    = r2_addr_reg;
        r2_data_next    = r2_data_reg;
        pend_ln_next    = pend_ln_reg;
        pend_rn_next    = pend_rn_reg;
        out_valid_next  = out_valid_reg && !pop_fire;
        out_status_next = out_status_reg;
        out_ln_next     = out_ln_reg;
        out_rn_next     = out_rn_reg;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;
        lw_en           = 1'b0;
        lw_addr         = '0;
        lw_data         = '0;
        rw_en           = 1'b0;
        rw_addr         = '0;
        rw_data         = '0;
        mw_en           = 1'b0;
        mw_addr         = '0;
        mw_data         = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mw_en   = 1'b1;
                mw_addr = clr_addr_reg;
                if (clr_addr_reg == AW'(ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cur_next   = q_item;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (ins_ok)
                begin
                    // first batch: the new entry's own links and mark
                    lw_en        = 1'b1;
                    lw_addr      = n_id;
                    rw_en        = 1'b1;
                    rw_addr      = n_id;
                    mw_en        = 1'b1;
                    mw_addr      = AW'(n_id);
                    mw_data      = '{removed: 1'b0, member: 1'b1};
                    pend_ln_next = res_ln;
                    pend_rn_next = res_rn;
                    state_next   = S_WR2;
                    if (cur_reg.req_type == REQ_INS_LEFT)
                    begin
                        lw_data      = la_q;
                        rw_data      = a_id;
                        l2_en_next   = 1'b1;
                        l2_addr_next = a_id;
                        l2_data_next = n_id;
                        r2_en_next   = (la_q != '0);
                        r2_addr_next = la_q;
                        r2_data_next = n_id;
                        if (la_q == '0)
                        begin
                            head_next = n_id;
                        end
                    end
                    else
                    begin
                        lw_data      = a_id;
                        rw_data      = succ;
                        l2_en_next   = (succ != '0);
                        l2_addr_next = succ;
                        l2_data_next = n_id;
                        r2_en_next   = !cur_reg.anchor_zero;
                        r2_addr_next = a_id;
                        r2_data_next = n_id;
                        if (cur_reg.anchor_zero)
                        begin
                            head_next = n_id;
                        end
                        if (succ == '0)
                        begin
                            tail_next = n_id;
                        end
                    end
                end
                else
                begin
                    if (rem_ok)
                    begin
                        // unlink in one batch: at most one write to each store
                        lw_en   = (ra_q != '0);
                        lw_addr = ra_q;
                        lw_data = la_q;
                        rw_en   = (la_q != '0);
                        rw_addr = la_q;
                        rw_data = ra_q;
                        mw_en   = 1'b1;
                        mw_addr = AW'(a_id);
                        mw_data = '{removed: 1'b1, member: 1'b0};
                        if (la_q == '0)
                        begin
                            head_next = ra_q;
                        end
                        if (ra_q == '0)
                        begin
                            tail_next = la_q;
                        end
                    end
                    out_valid_next  = 1'b1;
                    out_status_next = res_status;
                    out_ln_next     = res_ln;
                    out_rn_next     = res_rn;
                    out_first_next  = head_next;
                    out_last_next   = tail_next;
                    state_next      = S_IDLE;
                end
            end
            S_WR2:
            begin
                // second batch: neighbours point at the new entry
                lw_en           = l2_en_reg;
                lw_addr         = l2_addr_reg;
                lw_data         = l2_data_reg;
                rw_en           = r2_en_reg;
                rw_addr         = r2_addr_reg;
                rw_data         = r2_data_reg;
                out_valid_next  = 1'b1;
                out_status_next = ST_OK;
                out_ln_next     = pend_ln_reg;
                out_rn_next     = pend_rn_reg;
                out_first_next  = head_reg;
                out_last_next   = tail_reg;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        l2_en_reg      <= l2_en_next;
        l2_addr_reg    <= l2_addr_next;
        l2_data_reg    <= l2_data_next;
        r2_en_reg      <= r2_en_next;
        r2_addr_reg    <= r2_addr_next;
        r2_data_reg    <= r2_data_next;
        pend_ln_reg    <= pend_ln_next;
        pend_rn_reg    <= pend_rn_next;
        out_status_reg <= out_status_next;
        out_ln_reg     <= out_ln_next;
        out_rn_reg     <= out_rn_next;
        out_first_reg  <= out_first_next;
        out_last_reg   <= out_last_next;
    end

    assign empty          = !out_valid_reg;
    assign status         = out_status_reg;
    assign left_neighbor  = out_ln_reg;
    assign right_neighbor = out_rn_reg;
    assign first_entry    = out_first_reg;
    assign last_entry     = out_last_reg;

endmodule

`default_nettype wire

// ----- hdl/linked_list_table_unit.sv -----
// channel   direction  handshake        payload
// request   in         push / full      req_type, anchor_id, new_id
// result    out        empty / pop      status, left_neighbor, right_neighbor,
//                                       first_entry, last_entry
//
// in the back end every request reads the anchor links and marks; a query, a
// remove or a failed request then gets its result, a good insert writes the
// new entry's links and mark, then the neighbours' links in S_WR2, as each
// link store has a single write port. after reset the mark store is cleared
// one entry a cycle with full held high; a four-deep request queue lets beats
// arrive while the back end works or the result register waits for pop.
`timescale 1ns / 1ps
`default_nettype none

module linked_list_table_unit
    import llt_pkg::*;
#(
    parameter int ENTRIES = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [1:0]      req_type,
    input  wire logic [ID_W-1:0] anchor_id,
    input  wire logic [ID_W-1:0] new_id,
    output logic                 empty,
    input  wire logic            pop,
    output logic [1:0]           status,
    output logic [ID_W-1:0]      left_neighbor,
    output logic [ID_W-1:0]      right_neighbor,
    output logic [ID_W-1:0]      first_entry,
    output logic [ID_W-1:0]      last_entry
);

    logic clearing;
    logic q_valid;
    logic q_pop;
    req_t q_item;

    // request front: classify and queue
    llt_front #(.ENTRIES(ENTRIES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req_type  (req_type),
        .anchor_id (anchor_id),
        .new_id    (new_id),
        .clearing  (clearing),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // back end: table stores, sequencer and result register
    llt_back #(.ENTRIES(ENTRIES)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .clearing       (clearing),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .left_neighbor  (left_neighbor),
        .right_neighbor (right_neighbor),
        .first_entry    (first_entry),
        .last_entry     (last_entry)
    );

endmodule

`default_nettype wire

// ----- hdl/llt_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module llt_checker
    import llt_pkg::*;
(
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            push,
    input wire logic            full,
    input wire logic [1:0]      req_type,
    input wire logic [ID_W-1:0] anchor_id,
    input wire logic [ID_W-1:0] new_id,
    input wire logic            empty,
    input wire logic            pop,
    input wire logic [1:0]      status,
    input wire logic [ID_W-1:0] left_neighbor,
    input wire logic [ID_W-1:0] right_neighbor,
    input wire logic [ID_W-1:0] first_entry,
    input wire logic [ID_W-1:0] last_entry
);

    // leaving reset: no result and no beats taken while the marks are cleared
    a_reset_exit: assert property (@(posedge clk)
        $rose(rst_n) |-> (empty && full))
        else $error("result shown or request taken straight after reset");

    // a waiting result holds until popped
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(left_neighbor)
                              && $stable(right_neighbor) && $stable(first_entry)
                              && $stable(last_entry)))
        else $error("waiting result changed before pop");

    // a failed request reports no neighbours
    a_fail_no_links: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status != ST_OK)) |-> ((left_neighbor == '0) && (right_neighbor == '0)))
        else $error("failed request reports a neighbour");

    // first and last entry are empty together
    a_ends_agree: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((first_entry == '0) == (last_entry == '0)))
        else $error("first and last entry disagree on an empty list");

endmodule

bind linked_list_table_unit llt_checker u_llt_checker (.*);

`default_nettype wire

// ----- sim/linked_list_table_unit_tb.sv -----
`timescale 1ns / 1ps

module linked_list_table_unit_tb;
    import llt_pkg::*;

    localparam int TABLE_SIZE  = 1024;
    localparam int STALL_LIMIT = 6000;
    localparam int MAX_GAP     = 12;
    localparam int HOLD_OFF    = 300;
    localparam int TAIL_CYCLES = 30;

    typedef logic [ID_W-1:0] entry_t;

    // one result beat as the list model predicts it
    typedef struct packed {
        logic [1:0] st;
        entry_t     left_nb;
        entry_t     right_nb;
        entry_t     first_id;
        entry_t     last_id;
    } list_reply_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [1:0] req_type;
    entry_t     anchor_id;
    entry_t     new_id;
    logic       empty;
    logic       pop;
    logic [1:0] status;
    entry_t     left_neighbor;
    entry_t     right_neighbor;
    entry_t     first_entry;
    entry_t     last_entry;

    // list model state
    entry_t lnk_left [TABLE_SIZE];
    entry_t lnk_right [TABLE_SIZE];
    bit     on_list [TABLE_SIZE];
    bit     was_removed [TABLE_SIZE];
    entry_t head_succ;
    entry_t tail_id;
    entry_t live_ids [$];
    entry_t gone_ids [$];

    list_reply_t pending_replies [$];
    int          mismatches;
    bit          tx_idle_on;
    bit          rx_idle_on;
    int          rx_hold_cycles;

    linked_list_table_unit #(
        .ENTRIES(TABLE_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .req_type(req_type),
        .anchor_id(anchor_id),
        .new_id(new_id),
        .empty(empty),
        .pop(pop),
        .status(status),
        .left_neighbor(left_neighbor),
        .right_neighbor(right_neighbor),
        .first_entry(first_entry),
        .last_entry(last_entry)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // reset and initial drive
    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        pop            = 1'b0;
        req_type       = REQ_QUERY;
        anchor_id      = '0;
        new_id         = '0;
        head_succ      = '0;
        tail_id        = '0;
        mismatches     = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int draw_gap(input bit idle_on);
        return idle_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic bit is_member(input entry_t e);
        return e != '0 && on_list[e];
    endfunction

    function automatic entry_t succ_of(input entry_t e);
        return e == '0 ? head_succ : lnk_right[e];
    endfunction

    function automatic void set_succ(input entry_t e, input entry_t v);
        if (e == '0)
            head_succ = v;
        else
            lnk_right[e] = v;
    endfunction

    // splice entry n in just right of entry a
    function automatic void link_in(input entry_t a, input entry_t n);
        entry_t r;
        r = succ_of(a);
        lnk_left[n]  = a;
        lnk_right[n] = r;
        if (r != '0)
            lnk_left[r] = n;
        else
            tail_id = n;
        set_succ(a, n);
        on_list[n] = 1'b1;
        live_ids.push_back(n);
    endfunction

    // take entry x out for good
    function automatic void unlink(input entry_t x);
        entry_t l;
        entry_t r;
        l = lnk_left[x];
        r = lnk_right[x];
        set_succ(l, r);
        if (r != '0)
            lnk_left[r] = l;
        else
            tail_id = l;
        on_list[x]     = 1'b0;
        was_removed[x] = 1'b1;
        gone_ids.push_back(x);
        for (int i = 0; i < live_ids.size(); i++)
        begin
            if (live_ids[i] == x)
            begin
                live_ids.delete(i);
                break;
            end
        end
    endfunction

    // apply one request to the list model and return the reply it yields
    function automatic list_reply_t apply_list_request(input logic [1:0] kind, input entry_t a,
                                                       input entry_t n);
        list_reply_t r;
        r = '0;
        r.st = ST_OK;
        case (kind)
            REQ_INS_LEFT, REQ_INS_RIGHT:
            begin
                if (!((kind == REQ_INS_RIGHT && a == '0) || is_member(a)))
                    r.st = ST_NOT_IN_LIST;
                else if (n == '0 || on_list[n] || was_removed[n])
                    r.st = ST_BAD_NEW;
                else
                begin
                    if (kind == REQ_INS_LEFT)
                        link_in(lnk_left[a], n);
                    else
                        link_in(a, n);
                    r.left_nb  = (a == '0) ? entry_t'(0) : lnk_left[a];
                    r.right_nb = succ_of(a);
                end
            end
            REQ_REMOVE:
            begin
                if (is_member(a))
                begin
                    r.left_nb  = lnk_left[a];
                    r.right_nb = lnk_right[a];
                    unlink(a);
                end
                else if (a != '0 && was_removed[a])
                    r.st = ST_REMOVED;
                else
                    r.st = ST_NOT_IN_LIST;
            end
            default:
            begin
                if (a == '0)
                    r.right_nb = head_succ;
                else if (is_member(a))
                begin
                    r.left_nb  = lnk_left[a];
                    r.right_nb = lnk_right[a];
                end
                else
                    r.st = ST_NOT_IN_LIST;
            end
        endcase
        r.first_id = head_succ;
        r.last_id  = tail_id;
        return r;
    endfunction

    // an id that has never been linked; falls back to a used one when none is left
    function automatic entry_t pick_fresh_id();
        entry_t c;
        for (int t = 0; t < 8; t++)
        begin
            c = entry_t'($urandom_range(1, TABLE_SIZE - 1));
            if (!on_list[c] && !was_removed[c])
                return c;
        end
        for (int i = 1; i < TABLE_SIZE; i++)
        begin
            if (!on_list[i] && !was_removed[i])
                return entry_t'(i);
        end
        return entry_t'($urandom_range(1, TABLE_SIZE - 1));
    endfunction

    // a live entry, or the head when the list is empty
    function automatic entry_t pick_live_id();
        if (live_ids.size() == 0)
            return '0;
        return live_ids[$urandom_range(0, live_ids.size() - 1)];
    endfunction

    // offer one request beat and wait for it to be taken
    task automatic send_request(input logic [1:0] kind, input entry_t a, input entry_t n);
        int gap;
        gap = draw_gap(tx_idle_on);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        req_type  <= kind;
        anchor_id <= a;
        new_id    <= n;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_replies.push_back(apply_list_request(kind, a, n));
    endtask

    // stop offering and let every outstanding reply come back
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_field(input string name, input entry_t want, input entry_t got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // result side: pop with random gaps, check each beat against the oldest prediction
    initial
    begin
        int gap;
        list_reply_t want;
        @(posedge rst_n);
        @(posedge clk);
        pop <= 1'b1;
        forever
        begin
            @(posedge clk);
            gap = 0;
            if (pop && !empty)
            begin
                if (pending_replies.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with no request outstanding", $time);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    compare_field("status", entry_t'(want.st), entry_t'(status));
                    compare_field("left_neighbor", want.left_nb, left_neighbor);
                    compare_field("right_neighbor", want.right_nb, right_neighbor);
                    compare_field("first_entry", want.first_id, first_entry);
                    compare_field("last_entry", want.last_id, last_entry);
                end
                gap = draw_gap(rx_idle_on);
            end
            // long hold-off asked for by the back-pressure test
            if (rx_hold_cycles > 0)
            begin
                gap = gap + rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
                pop <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat moving either way
    initial
    begin
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // requests against an empty list
    task automatic test_empty_list();
        send_request(REQ_QUERY, 10'd0, 10'd0);
        send_request(REQ_REMOVE, 10'd0, 10'd0);
        send_request(REQ_INS_LEFT, 10'd0, 10'd9);
        send_request(REQ_QUERY, 10'd5, 10'd0);
        send_request(REQ_REMOVE, 10'd7, 10'd0);
    endtask

    // inserts at both ends and around the head, plus bad new ids
    task automatic test_insert_order();
        send_request(REQ_INS_RIGHT, 10'd0, 10'd1023);
        send_request(REQ_INS_LEFT, 10'd1023, 10'd1);
        send_request(REQ_INS_RIGHT, 10'd1023, 10'd512);
        send_request(REQ_INS_RIGHT, 10'd0, 10'd2);
        send_request(REQ_QUERY, 10'd1023, 10'd0);
        send_request(REQ_QUERY, 10'd0, 10'd0);
        send_request(REQ_INS_LEFT, 10'd2, 10'd3);
        send_request(REQ_INS_RIGHT, 10'd1, 10'd0);
        send_request(REQ_INS_LEFT, 10'd512, 10'd1023);
    endtask

    // removes at first and last, repeat removes and ids that may not come back
    task automatic test_remove_and_reuse();
        send_request(REQ_REMOVE, 10'd3, 10'd0);
        send_request(REQ_REMOVE, 10'd512, 10'd0);
        send_request(REQ_REMOVE, 10'd512, 10'd0);
        send_request(REQ_INS_RIGHT, 10'd1, 10'd512);
        send_request(REQ_INS_LEFT, 10'd512, 10'd5);
        send_request(REQ_QUERY, 10'd512, 10'd0);
        send_request(REQ_REMOVE, 10'd1023, 10'd0);
        send_request(REQ_REMOVE, 10'd2, 10'd0);
        send_request(REQ_REMOVE, 10'd1, 10'd0);
        send_request(REQ_QUERY, 10'd0, 10'd0);
        send_request(REQ_INS_RIGHT, 10'd0, 10'd4);
    endtask

    // receiver holds off while the sender keeps pushing, so full has to rise
    task automatic test_backpressure();
        tx_idle_on     = 1'b0;
        rx_hold_cycles = HOLD_OFF;
        for (int k = 0; k < 24; k++)
            send_request(REQ_INS_RIGHT, pick_live_id(), pick_fresh_id());
        wait_drained();
        tx_idle_on = 1'b1;
    endtask

    // mostly well-formed list traffic, with broken requests and raw noise mixed in
    task automatic test_random_traffic(input int count);
        int sel;
        logic [1:0] kind;
        entry_t a;
        entry_t n;
        for (int k = 0; k < count; k++)
        begin
            // new idling mix every block, sometimes with a full drain first
            if (k % 125 == 0)
            begin
                if ($urandom_range(0, 2) == 0)
                    wait_drained();
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            sel = $urandom_range(0, 99);
            n   = entry_t'($urandom);
            if (sel < 45)
            begin
                kind = $urandom_range(0, 1) ? REQ_INS_RIGHT : REQ_INS_LEFT;
                a    = ($urandom_range(0, 7) == 0) ? entry_t'(0) : pick_live_id();
                if (a == '0)
                    kind = REQ_INS_RIGHT;
                n = pick_fresh_id();
            end
            else if (sel < 70)
            begin
                kind = REQ_REMOVE;
                a    = (live_ids.size() != 0) ? pick_live_id() : entry_t'($urandom);
            end
            else if (sel < 82)
            begin
                kind = REQ_QUERY;
                a    = ($urandom_range(0, 4) == 0) ? entry_t'(0) : pick_live_id();
            end
            else if (sel < 90)
            begin
                // broken requests: stale anchors, used new ids, head misuse
                a = (gone_ids.size() != 0) ? gone_ids[$urandom_range(0, gone_ids.size() - 1)]
                                           : entry_t'($urandom);
                case ($urandom_range(0, 4))
                    0: kind = REQ_REMOVE;
                    1: kind = REQ_QUERY;
                    2:
                    begin
                        kind = REQ_INS_RIGHT;
                        a    = pick_live_id();
                        n    = (gone_ids.size() != 0 && $urandom_range(0, 1)) ? a : pick_live_id();
                    end
                    3:
                    begin
                        kind = REQ_INS_LEFT;
                        a    = '0;
                    end
                    default:
                    begin
                        kind = REQ_REMOVE;
                        a    = '0;
                    end
                endcase
            end
            else
            begin
                kind = 2'($urandom_range(0, 3));
                a    = entry_t'($urandom);
            end
            send_request(kind, a, n);
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // test sequence
    initial
    begin
        @(posedge rst_n);
        @(posedge clk);
        test_empty_list();
        test_insert_order();
        test_remove_and_reuse();
        wait_drained();
        test_backpressure();
        test_random_traffic(1250);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/llt_pkg.sv
hdl/llt_ram.sv
hdl/llt_front.sv
hdl/llt_back.sv
hdl/linked_list_table_unit.sv
hdl/llt_checker.sv
sim/linked_list_table_unit_tb.sv
